// File: hw/rtl/kwe_pkg.sv
// ----------------------------------------------------------------------------
// kwe_pkg
// shared types and constants for the rolling k-mer window extractor
// ----------------------------------------------------------------------------
package kwe_pkg;

    localparam int BASE_W       = 2;
    localparam int CHAR_W       = 8;
    localparam int PREFIX_OUT_W = 12;
    localparam int SUFFIX_OUT_W = 32;
    localparam int OUT_DATA_W   = 2 * PREFIX_OUT_W + 2 * SUFFIX_OUT_W;

    // ascii codes of the accepted bases
    localparam logic [CHAR_W-1:0] CHAR_A_UP = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C_UP = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G_UP = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_T_UP = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_A_LO = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_C_LO = 8'h63;
    localparam logic [CHAR_W-1:0] CHAR_G_LO = 8'h67;
    localparam logic [CHAR_W-1:0] CHAR_T_LO = 8'h74;

    localparam logic [BASE_W-1:0] CODE_A = 2'd0;
    localparam logic [BASE_W-1:0] CODE_C = 2'd1;
    localparam logic [BASE_W-1:0] CODE_G = 2'd2;
    localparam logic [BASE_W-1:0] CODE_T = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [BASE_W-1:0] code;
    } kwe_base_t;

endpackage

// File: hw/rtl/kwe_decode.sv
// ----------------------------------------------------------------------------
// kwe_decode
// maps a raw sequence byte to a 2-bit base code and a valid flag
// ----------------------------------------------------------------------------
module kwe_decode
    import kwe_pkg::*;
(
    input  logic [CHAR_W-1:0] base_char,
    output kwe_base_t         base
);

    always_comb
    begin
        unique case (base_char)
            CHAR_A_UP, CHAR_A_LO: base = '{valid: 1'b1, code: CODE_A};
            CHAR_C_UP, CHAR_C_LO: base = '{valid: 1'b1, code: CODE_C};
            CHAR_G_UP, CHAR_G_LO: base = '{valid: 1'b1, code: CODE_G};
            CHAR_T_UP, CHAR_T_LO: base = '{valid: 1'b1, code: CODE_T};
            default:              base = '{valid: 1'b0, code: CODE_A};
        endcase
    end

endmodule

// File: hw/rtl/kwe_cell.sv
// ----------------------------------------------------------------------------
// kwe_cell
// one window position: holds a base and takes its neighbour's on a shift
// ----------------------------------------------------------------------------
module kwe_cell
    import kwe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift_en,
    input  logic [BASE_W-1:0] base_in,
    output logic [BASE_W-1:0] base_q,
    output logic [BASE_W-1:0] base_d
);

    logic [BASE_W-1:0] base_reg;
    logic [BASE_W-1:0] base_next;

    assign base_next = shift_en ? base_in : base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else
        begin
            base_reg <= base_next;
        end
    end

    assign base_q = base_reg;
    assign base_d = base_next;

endmodule

// File: hw/rtl/kmer_window_extract.sv
// ----------------------------------------------------------------------------
// kmer_window_extract
// rolling 2-bit k-mer windows over a character stream, split into bin
// prefix and suffix for forward and reversed base order
// ----------------------------------------------------------------------------
// channel   dir  tdata fields (low bit up)
// s_axis    in   base_char[7:0]
// m_axis    out  fwd_prefix[11:0] fwd_suffix[43:12] rev_prefix[55:44]
//                rev_suffix[87:56]
//
// one character per cycle; the window update and the result are formed in
// the cycle the transaction is accepted and held in a single output register
// a new character is taken whenever the output register is empty or drained
// in the same cycle, so a stall on m_axis holds s_axis only while a result
// waits; reset clears the cell chain, the fill count and the output valid
// the reverse window is the cell chain read in reversed base order
// ----------------------------------------------------------------------------
module kmer_window_extract
    import kwe_pkg::*;
#(
    parameter int KMER_BASES   = 22,
    parameter int PREFIX_BASES = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [CHAR_W-1:0]     s_axis_tdata,   // base_char
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // fwd_prefix, fwd_suffix,
                                                  // rev_prefix, rev_suffix
);

    localparam int WIN_BITS = BASE_W * KMER_BASES;
    localparam int PRE_BITS = BASE_W * PREFIX_BASES;
    localparam int SUF_BITS = WIN_BITS - PRE_BITS;
    localparam int CNT_W    = $clog2(KMER_BASES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(KMER_BASES);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(KMER_BASES - 1);

    kwe_base_t base;
    logic      in_accept;
    logic      result;

    logic [WIN_BITS-1:0] fwd_q;
    logic [WIN_BITS-1:0] fwd_d;
    logic [WIN_BITS-1:0] rev_d;

    logic [CNT_W-1:0] fill_cnt_reg;
    logic [CNT_W-1:0] fill_cnt_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    kwe_decode u_decode
    (
        .base_char (s_axis_tdata),
        .base      (base)
    );

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // newest base enters cell 0 and moves up one cell per valid base
    genvar j;
    generate
        for (j = 0; j < KMER_BASES; j++)
        begin : g_cell
            logic [BASE_W-1:0] link_in;
            if (j == 0)
            begin : g_head
                assign link_in = base.code;
            end
            else
            begin : g_body
                assign link_in = fwd_q[BASE_W*(j-1) +: BASE_W];
            end

            kwe_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (in_accept && base.valid),
                .base_in  (link_in),
                .base_q   (fwd_q[BASE_W*j +: BASE_W]),
                .base_d   (fwd_d[BASE_W*j +: BASE_W])
            );

            assign rev_d[BASE_W*(KMER_BASES-1-j) +: BASE_W] = fwd_d[BASE_W*j +: BASE_W];
        end
    endgenerate

    // fill count of the current run, saturating once the window is full
    always_comb
    begin
        fill_cnt_next = fill_cnt_reg;
        if (in_accept)
        begin
            if (!base.valid)
            begin
                fill_cnt_next = '0;
            end
            else if (fill_cnt_reg != FULL_CNT)
            begin
                fill_cnt_next = fill_cnt_reg + 1'b1;
            end
        end
    end

    assign result = in_accept && base.valid
                    && (fill_cnt_reg == FULL_CNT || fill_cnt_reg == LAST_CNT);

    // zero-extend before trimming so narrow or wide parts both fit the fields
    logic [PRE_BITS+PREFIX_OUT_W-1:0] fwd_pre_ext;
    logic [SUF_BITS+SUFFIX_OUT_W-1:0] fwd_suf_ext;
    logic [PRE_BITS+PREFIX_OUT_W-1:0] rev_pre_ext;
    logic [SUF_BITS+SUFFIX_OUT_W-1:0] rev_suf_ext;

    assign fwd_pre_ext = {{PREFIX_OUT_W{1'b0}}, fwd_d[WIN_BITS-1:SUF_BITS]};
    assign fwd_suf_ext = {{SUFFIX_OUT_W{1'b0}}, fwd_d[SUF_BITS-1:0]};
    assign rev_pre_ext = {{PREFIX_OUT_W{1'b0}}, rev_d[PRE_BITS-1:0]};
    assign rev_suf_ext = {{SUFFIX_OUT_W{1'b0}}, rev_d[WIN_BITS-1:PRE_BITS]};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (result)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {rev_suf_ext[SUFFIX_OUT_W-1:0], rev_pre_ext[PREFIX_OUT_W-1:0],
                              fwd_suf_ext[SUFFIX_OUT_W-1:0], fwd_pre_ext[PREFIX_OUT_W-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_cnt_reg  <= fill_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // a non-base character always restarts the run
    a_break_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !base.valid) |=> (fill_cnt_reg == '0))
        else $error("fill count not cleared after a non-base transaction");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_cnt_reg <= FULL_CNT)
        else $error("fill count beyond window length");

    a_full_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && base.valid && fill_cnt_reg == LAST_CNT) |=> out_valid_reg)
        else $error("no result when the window filled");

    a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_accept && base.valid))
        else $error("result appeared without an accepted base");

    a_no_result_short_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (!base.valid || (fill_cnt_reg != FULL_CNT && fill_cnt_reg != LAST_CNT))
         && m_axis_tready) |=> !out_valid_reg)
        else $error("result issued before the window was full");

endmodule
